// ----- hdl/uot_pkg.sv -----
package uot_pkg;

    localparam int unsigned CHAR_W   = 9;
    localparam int unsigned TXSR_W   = 13;
    localparam int unsigned RXSR_W   = 16;
    localparam int unsigned COUNT_W  = 24;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 24;

    // parity modes; the unused code behaves as even parity
    localparam logic [1:0] PAR_NONE = 2'd0;
    localparam logic [1:0] PAR_ODD  = 2'd1;
    localparam logic [1:0] PAR_EVEN = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NINE_DATA_BITS = 3'd0,
        CFG_PARITY_MODE    = 3'd1,
        CFG_TWO_STOP_BITS  = 3'd2,
        CFG_INTER_BYTE_GAP = 3'd3,
        CFG_IDLE_TIMEOUT   = 3'd4
    } t_cfg_reg;

    typedef enum logic [1:0] {
        RX_OK         = 2'd0,
        RX_OK_TIMEOUT = 2'd1,
        RX_BAD_PARITY = 2'd2,
        RX_FRAME_ERR  = 2'd3
    } t_rx_status;

    localparam logic signed [8:0] TX_PH_LAST   = 9'sd4;
    localparam logic signed [8:0] TX_PH_RESET  = -9'sd3;
    localparam logic [2:0]        RX_PH_IDLE   = 3'd0;
    localparam logic [2:0]        RX_PH_FIRST  = 3'd1;
    localparam logic [2:0]        RX_PH_SAMPLE = 3'd3;
    localparam logic [2:0]        RX_PH_LAST   = 3'd5;
    localparam logic [RXSR_W-1:0] RX_SHIFT_IDLE = 16'hFFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 24'hFFFFFF;
    localparam logic [7:0]        GAP_RESET    = 8'd3;
    localparam logic [COUNT_W-1:0] TIMEOUT_RESET = 24'd86;

    typedef struct packed {
        logic               nine_data_bits;
        logic [1:0]         parity_mode;
        logic               two_stop_bits;
        logic [7:0]         inter_byte_gap;
        logic [COUNT_W-1:0] idle_timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic tx_line;
        logic tx_taken;
        logic tx_frame_done;
    } t_tx_res;

    typedef struct packed {
        logic              rx_valid;
        logic [CHAR_W-1:0] rx_char;
        t_rx_status        rx_status;
        logic              rx_timeout_event;
    } t_rx_res;

    function automatic logic [CHAR_W-1:0] data_mask(input logic nine);
        data_mask = nine ? 9'h1FF : 9'h0FF;
    endfunction

    function automatic logic [3:0] data_bits(input logic nine);
        data_bits = nine ? 4'd9 : 4'd8;
    endfunction

    // parity bit for the data bits of d under the given mode
    function automatic logic parity_of(input logic [CHAR_W-1:0] d, input logic nine,
                                       input logic [1:0] mode);
        parity_of = (^(d & data_mask(nine))) ^ (mode == PAR_ODD);
    endfunction

endpackage

// ----- hdl/uot_if.sv -----
interface uot_in_if;
    logic                        valid;
    logic                        ready;
    logic                        tick;
    logic                        rx_line;
    logic                        tx_valid;
    logic [uot_pkg::CHAR_W-1:0]  tx_char;

    modport source (output valid, tick, rx_line, tx_valid, tx_char, input ready);
    modport sink   (input valid, tick, rx_line, tx_valid, tx_char, output ready);
endinterface

interface uot_out_if;
    logic                        valid;
    logic                        ready;
    logic                        tx_line;
    logic                        tx_taken;
    logic                        tx_frame_done;
    logic                        rx_valid;
    logic [uot_pkg::CHAR_W-1:0]  rx_char;
    logic [1:0]                  rx_status;
    logic                        rx_timeout_event;

    modport source (output valid, tx_line, tx_taken, tx_frame_done, rx_valid, rx_char,
                    rx_status, rx_timeout_event, input ready);
    modport sink   (input valid, tx_line, tx_taken, tx_frame_done, rx_valid, rx_char,
                    rx_status, rx_timeout_event, output ready);
endinterface

interface uot_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [uot_pkg::CFG_IDX_W-1:0] index;
    logic [uot_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/uot_tx.sv -----
module uot_tx (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  uot_pkg::t_cfg              i_cfg,
    input  logic                       i_tick,
    input  logic                       i_tx_valid,
    input  logic [uot_pkg::CHAR_W-1:0] i_tx_char,
    output uot_pkg::t_tx_res           o_res
);
    import uot_pkg::*;

    logic [TXSR_W-1:0] r_shift, n_shift;
    logic signed [8:0] r_phase, n_phase;
    logic              r_level, n_level;
    logic [11:0]       w_frame;
    logic [CHAR_W-1:0] w_data;
    logic              w_par_on;
    logic [3:0]        w_db;

    // frame image: data, optional parity, stop bits; start bit added by the shift
    always_comb begin
        w_data   = i_tx_char & data_mask(i_cfg.nine_data_bits);
        w_par_on = (i_cfg.parity_mode != PAR_NONE);
        w_db     = data_bits(i_cfg.nine_data_bits);
        w_frame  = {3'b000, w_data};
        if (w_par_on) begin
            w_frame = w_frame
                | (12'(parity_of(w_data, i_cfg.nine_data_bits, i_cfg.parity_mode)) << w_db);
        end
        w_frame = w_frame
            | ((i_cfg.two_stop_bits ? 12'd3 : 12'd1) << (w_db + 4'(w_par_on)));
    end

    always_comb begin
        n_shift = r_shift;
        n_phase = r_phase;
        n_level = r_level;
        o_res   = '0;
        if (i_tick) begin
            if (r_shift != '0) begin
                if (r_phase == TX_PH_LAST) begin
                    n_shift = r_shift >> 1;
                    if (n_shift != '0) begin
                        n_level = n_shift[0];
                        n_phase = '0;
                    end else begin
                        n_phase = -$signed({1'b0, i_cfg.inter_byte_gap});
                        o_res.tx_frame_done = 1'b1;
                    end
                end else if (r_phase < TX_PH_LAST) begin
                    n_phase = r_phase + 9'sd1;
                end
            end
            if (n_shift == '0) begin
                if (n_phase < 9'sd0) begin
                    n_phase = n_phase + 9'sd1;
                end else if (i_tx_valid) begin
                    n_shift = {w_frame, 1'b0};
                    n_level = 1'b0;
                    o_res.tx_taken = 1'b1;
                end
            end
        end
        o_res.tx_line = n_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
            r_phase <= TX_PH_RESET;
            r_level <= 1'b1;
        end else if (i_en) begin
            r_shift <= n_shift;
            r_phase <= n_phase;
            r_level <= n_level;
        end
    end

endmodule

// ----- hdl/uot_rx.sv -----
module uot_rx (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_clr,
    input  uot_pkg::t_cfg    i_cfg,
    input  logic             i_tick,
    input  logic             i_rx_line,
    output uot_pkg::t_rx_res o_res
);
    import uot_pkg::*;

    logic [RXSR_W-1:0]  r_shift, n_shift;
    logic [2:0]         r_phase, n_phase;
    logic               r_prev, n_prev;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_timed, n_timed;
    logic [14:0]        w_d;
    logic [14:0]        w_sm;
    logic [3:0]         w_db;
    logic               w_par_on;
    logic [3:0]         w_top;
    logic               w_par_ok;
    logic               w_stop_ok;

    always_comb begin
        w_db     = data_bits(i_cfg.nine_data_bits);
        w_par_on = (i_cfg.parity_mode != PAR_NONE);
        w_top    = 4'd1 + w_db + 4'(w_par_on) + 4'(i_cfg.two_stop_bits);
        w_sm     = (i_cfg.two_stop_bits ? 15'd3 : 15'd1) << (w_db + 4'(w_par_on));
        n_shift  = r_shift;
        n_phase  = r_phase;
        n_prev   = r_prev;
        n_count  = r_count;
        n_timed  = r_timed;
        w_d      = '0;
        w_par_ok = 1'b1;
        w_stop_ok = 1'b1;
        o_res    = '0;
        if (i_tick) begin
            if (r_phase != RX_PH_IDLE) begin
                if (r_phase == RX_PH_SAMPLE) begin
                    // shift in a one, then clear the frame's last slot on a low sample
                    n_shift = {1'b1, r_shift[RXSR_W-1:1]};
                    if (!i_rx_line) begin
                        n_shift = n_shift & ~(16'd1 << w_top);
                    end
                end
                if (n_shift[0]) begin
                    n_phase = (r_phase >= RX_PH_LAST) ? RX_PH_FIRST : r_phase + 3'd1;
                end else begin
                    w_d = n_shift[RXSR_W-1:1];
                    if (w_par_on) begin
                        w_par_ok = (w_d[w_db] == parity_of(w_d[CHAR_W-1:0],
                                    i_cfg.nine_data_bits, i_cfg.parity_mode));
                    end
                    w_stop_ok = ((w_d & w_sm) == w_sm);
                    if (!w_stop_ok) begin
                        o_res.rx_status = RX_FRAME_ERR;
                    end else if (!w_par_ok) begin
                        o_res.rx_status = RX_BAD_PARITY;
                    end else begin
                        o_res.rx_status = r_timed ? RX_OK_TIMEOUT : RX_OK;
                    end
                    o_res.rx_valid = 1'b1;
                    o_res.rx_char  = w_d[CHAR_W-1:0] & data_mask(i_cfg.nine_data_bits);
                    n_timed = 1'b0;
                    n_shift = RX_SHIFT_IDLE;
                    n_phase = RX_PH_IDLE;
                end
            end else if (r_prev && !i_rx_line) begin
                n_count = '0;
                n_phase = RX_PH_FIRST;
            end else if (!r_timed) begin
                if (r_count != COUNT_MAX) begin
                    n_count = r_count + 24'd1;
                end
                if (n_count >= i_cfg.idle_timeout_ticks) begin
                    n_timed = 1'b1;
                    o_res.rx_timeout_event = 1'b1;
                end
            end
            n_prev = i_rx_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= RX_SHIFT_IDLE;
            r_phase <= RX_PH_IDLE;
            r_prev  <= 1'b1;
            r_count <= '0;
            r_timed <= 1'b0;
        end else begin
            if (i_en) begin
                r_shift <= n_shift;
                r_phase <= n_phase;
                r_prev  <= n_prev;
                r_count <= n_count;
                r_timed <= n_timed;
            end
            if (i_clr) begin
                r_count <= '0;
                r_timed <= 1'b0;
            end
        end
    end

endmodule

// ----- hdl/uart_oversampled_tx_rx.sv -----
// UART transmitter and receiver with 5x oversampling. Each input beat is one
// oversample tick (tick=0 beats change nothing and return only the line level);
// every accepted beat yields exactly one registered output beat, and a new
// beat is taken every cycle as long as the output side keeps up: the only
// storage in the path is the transmit and receive state plus one output register.
// Frames are LSB first: start bit, 8 or 9 data bits, optional odd/even parity,
// 1 or 2 stop bits, 5 ticks per bit, then inter_byte_gap idle ticks. The
// receiver samples at the fourth tick of each bit, reports framing errors ahead
// of parity errors, and tags the first frame after an idle timeout. Writing
// idle_timeout_ticks restarts the idle counter. Write registers only while idle.
module uart_oversampled_tx_rx (
    input  logic   i_clk,
    input  logic   i_rst_n,
    uot_in_if.sink    i_in,
    uot_out_if.source o_out,
    uot_cfg_if.sink   i_cfg
);
    import uot_pkg::*;

    t_cfg    r_cfg;
    t_tx_res w_tx;
    t_rx_res w_rx;
    logic    w_accept;
    logic    w_clr;
    logic    r_out_valid;
    t_tx_res r_tx;
    t_rx_res r_rx;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign w_accept    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign w_clr       = i_cfg.valid && (i_cfg.index == CFG_IDLE_TIMEOUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.nine_data_bits     <= 1'b0;
            r_cfg.parity_mode        <= PAR_NONE;
            r_cfg.two_stop_bits      <= 1'b0;
            r_cfg.inter_byte_gap     <= GAP_RESET;
            r_cfg.idle_timeout_ticks <= TIMEOUT_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_NINE_DATA_BITS: r_cfg.nine_data_bits     <= i_cfg.data[0];
                CFG_PARITY_MODE:    r_cfg.parity_mode        <= i_cfg.data[1:0];
                CFG_TWO_STOP_BITS:  r_cfg.two_stop_bits      <= i_cfg.data[0];
                CFG_INTER_BYTE_GAP: r_cfg.inter_byte_gap     <= i_cfg.data[7:0];
                CFG_IDLE_TIMEOUT:   r_cfg.idle_timeout_ticks <= i_cfg.data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    uot_tx u_tx (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_accept),
        .i_cfg      (r_cfg),
        .i_tick     (i_in.tick),
        .i_tx_valid (i_in.tx_valid),
        .i_tx_char  (i_in.tx_char),
        .o_res      (w_tx)
    );

    uot_rx u_rx (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_accept),
        .i_clr     (w_clr),
        .i_cfg     (r_cfg),
        .i_tick    (i_in.tick),
        .i_rx_line (i_in.rx_line),
        .o_res     (w_rx)
    );

    // hold the result until taken; refill in the same cycle it drains
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tx <= w_tx;
            r_rx <= w_rx;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.tx_line          = r_tx.tx_line;
    assign o_out.tx_taken         = r_tx.tx_taken;
    assign o_out.tx_frame_done    = r_tx.tx_frame_done;
    assign o_out.rx_valid         = r_rx.rx_valid;
    assign o_out.rx_char          = r_rx.rx_char;
    assign o_out.rx_status        = r_rx.rx_status;
    assign o_out.rx_timeout_event = r_rx.rx_timeout_event;

endmodule
